// ----- hdl/sled_pkg.sv -----
// Shared types, constants and helpers for the string literal escape decoder.
package sled_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CODE_W     = 8;
    localparam int BCOUNT_W   = 16;

    localparam int FIFO_DEPTH = 4;   // power of two, pointers wrap naturally
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam int ADDR_W     = 3;   // two 32-bit registers at byte 0 and 4

    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_ESC_EN    = 1'b1;

    localparam logic [7:0] DELIM_RESET  = 8'd34;
    localparam logic       ESC_EN_RESET = 1'b1;

    localparam logic [7:0] CH_NUL       = 8'd0;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_DQUOTE    = 8'd34;
    localparam logic [7:0] CH_SQUOTE    = 8'd39;
    localparam logic [7:0] CH_ESCAPE    = 8'd27;
    localparam logic [7:0] CH_BSPACE    = 8'd8;
    localparam logic [7:0] CH_FFEED     = 8'd12;
    localparam logic [7:0] CH_LFEED     = 8'd10;
    localparam logic [7:0] CH_CRET      = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    localparam logic [7:0] LTR_B  = 8'h62;
    localparam logic [7:0] LTR_F  = 8'h66;
    localparam logic [7:0] LTR_N  = 8'h6E;
    localparam logic [7:0] LTR_R  = 8'h72;
    localparam logic [7:0] LTR_T  = 8'h74;
    localparam logic [7:0] LTR_E  = 8'h65;
    localparam logic [7:0] LTR_X  = 8'h78;
    localparam logic [7:0] LTR_UX = 8'h58;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_MISSING = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        kind_t               kind;
        logic [BCOUNT_W-1:0] byte_count;
        logic                last;
    } result_t;

    // results produced by one accepted character, first in order
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == '1) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

// ----- hdl/sled_ifs.sv -----
// Valid/ready channel interfaces for character input and decoded result output.
interface sled_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source(output valid, output ch, input ready);
    modport sink(input valid, input ch, output ready);
endinterface

interface sled_out_if;
    logic                             valid;
    logic                             ready;
    logic [sled_pkg::CODE_W-1:0]      code;
    sled_pkg::kind_t                  kind;
    logic [sled_pkg::BCOUNT_W-1:0]    byte_count;
    logic                             last;

    modport source(output valid, output code, output kind, output byte_count,
                   output last, input ready);
    modport sink(input valid, input code, input kind, input byte_count,
                 input last, output ready);
endinterface

// ----- hdl/sled_decode.sv -----
// Literal parser state and per-character decode into up to two results.
module sled_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            ch,
    input  logic [7:0]            delimiter,
    input  logic                  esc_en,
    output sled_pkg::push_t       push
);

    typedef enum logic [2:0] {
        PH_OPEN  = 3'd0,
        PH_BODY  = 3'd1,
        PH_QUOTE = 3'd2,
        PH_ESC   = 3'd3,
        PH_OCT   = 3'd4,
        PH_HEX   = 3'd5
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [7:0]                        accum_reg, accum_next;
    logic [sled_pkg::COUNT_BITS-1:0]   count_reg;

    // ordinary body character handling
    logic            body_emit;
    logic [7:0]      body_code;
    sled_pkg::kind_t body_kind;
    phase_t          body_phase;

    // leading result and control
    logic            a_valid;
    logic [7:0]      a_code;
    sled_pkg::kind_t a_kind;
    logic            use_body;
    logic            clear_count;
    phase_t          a_phase;

    logic [4:0]      hexd;
    logic            is_oct;
    logic            b_valid;

    logic [sled_pkg::COUNT_BITS-1:0] cnt0, cnt_a, cnt_b;

    assign hexd   = sled_pkg::hex_digit(ch);
    assign is_oct = (ch[7:3] == 5'b00110);

    always_comb
    begin
        body_emit  = 1'b1;
        body_code  = ch;
        body_kind  = sled_pkg::KIND_BYTE;
        body_phase = PH_BODY;
        if (ch == sled_pkg::CH_NUL)
        begin
            body_code  = sled_pkg::CH_NUL;
            body_kind  = sled_pkg::KIND_MISSING;
            body_phase = PH_OPEN;
        end
        else if (ch == sled_pkg::CH_BACKSLASH)
        begin
            // backslash wins over a delimiter of the same code
            if (esc_en)
            begin
                body_emit  = 1'b0;
                body_phase = PH_ESC;
            end
        end
        else if (ch == delimiter)
        begin
            body_emit  = 1'b0;
            body_phase = PH_QUOTE;
        end
    end

    always_comb
    begin
        a_valid     = 1'b0;
        a_code      = ch;
        a_kind      = sled_pkg::KIND_BYTE;
        use_body    = 1'b0;
        clear_count = 1'b0;
        a_phase     = phase_reg;
        accum_next  = accum_reg;
        case (phase_reg)
            PH_OPEN:
            begin
                if (ch == sled_pkg::CH_NUL)
                begin
                    a_valid = 1'b1;
                    a_code  = sled_pkg::CH_NUL;
                    a_kind  = sled_pkg::KIND_MISSING;
                end
                else
                begin
                    clear_count = 1'b1;
                    accum_next  = '0;
                    if (ch == delimiter)
                        a_phase = PH_BODY;
                    else
                    begin
                        // missing opener: flag it, then treat as first body char
                        a_valid  = 1'b1;
                        a_code   = sled_pkg::CH_NUL;
                        a_kind   = sled_pkg::KIND_MISSING;
                        use_body = 1'b1;
                    end
                end
            end
            PH_BODY:
                use_body = 1'b1;
            PH_QUOTE:
            begin
                a_valid = 1'b1;
                if (ch != sled_pkg::CH_NUL && ch == delimiter)
                    a_phase = PH_BODY;          // doubled delimiter
                else
                begin
                    a_kind  = sled_pkg::KIND_END;
                    a_phase = PH_OPEN;
                end
            end
            PH_ESC:
            begin
                a_valid = 1'b1;
                a_phase = PH_BODY;
                case (ch)
                    sled_pkg::CH_NUL:
                    begin
                        a_kind  = sled_pkg::KIND_MISSING;
                        a_phase = PH_OPEN;
                    end
                    sled_pkg::LTR_B:        a_code = sled_pkg::CH_BSPACE;
                    sled_pkg::LTR_F:        a_code = sled_pkg::CH_FFEED;
                    sled_pkg::LTR_N:        a_code = sled_pkg::CH_LFEED;
                    sled_pkg::LTR_R:        a_code = sled_pkg::CH_CRET;
                    sled_pkg::LTR_T:        a_code = sled_pkg::CH_TAB;
                    sled_pkg::CH_BACKSLASH: a_code = sled_pkg::CH_BACKSLASH;
                    sled_pkg::CH_DQUOTE:    a_code = sled_pkg::CH_DQUOTE;
                    sled_pkg::CH_SQUOTE:    a_code = sled_pkg::CH_SQUOTE;
                    sled_pkg::LTR_E:        a_code = sled_pkg::CH_ESCAPE;
                    sled_pkg::LTR_X, sled_pkg::LTR_UX:
                    begin
                        a_valid    = 1'b0;
                        accum_next = '0;
                        a_phase    = PH_HEX;
                    end
                    default:
                    begin
                        if (is_oct)
                        begin
                            a_valid    = 1'b0;
                            accum_next = {5'd0, ch[2:0]};
                            a_phase    = PH_OCT;
                        end
                        else
                        begin
                            // unknown escape, char is then decoded normally
                            a_kind   = sled_pkg::KIND_UNKNOWN;
                            use_body = 1'b1;
                        end
                    end
                endcase
            end
            PH_OCT:
            begin
                if (is_oct)
                    accum_next = {accum_reg[4:0], ch[2:0]};
                else
                begin
                    a_valid  = 1'b1;
                    a_code   = accum_reg;
                    use_body = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (hexd[4])
                    accum_next = {accum_reg[3:0], hexd[3:0]};
                else
                begin
                    a_valid  = 1'b1;
                    a_code   = accum_reg;
                    use_body = 1'b1;
                end
            end
            default:
                a_phase = PH_OPEN;
        endcase
    end

    assign phase_next = use_body ? body_phase : a_phase;
    assign b_valid    = use_body & body_emit;

    assign cnt0  = clear_count ? '0 : count_reg;
    assign cnt_a = (a_valid && a_kind == sled_pkg::KIND_BYTE) ? sled_pkg::sat_inc(cnt0) : cnt0;
    assign cnt_b = (b_valid && body_kind == sled_pkg::KIND_BYTE) ?
                   sled_pkg::sat_inc(cnt_a) : cnt_a;

    always_comb
    begin
        push.n = accept ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;

        push.second.code       = body_code;
        push.second.kind       = body_kind;
        push.second.byte_count = sled_pkg::BCOUNT_W'(cnt_b);
        push.second.last       = 1'b1;

        if (a_valid)
        begin
            push.first.code       = a_code;
            push.first.kind       = a_kind;
            push.first.byte_count = sled_pkg::BCOUNT_W'(cnt_a);
            push.first.last       = ~b_valid;
        end
        else
            push.first = push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            accum_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            count_reg <= cnt_b;
        end
    end

endmodule

// ----- hdl/sled_fifo.sv -----
// Small result queue: takes up to two words per cycle, gives one per cycle.
module sled_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  sled_pkg::push_t   push,
    input  logic              pop,
    output sled_pkg::result_t head,
    output logic              head_valid,
    output logic              room
);

    sled_pkg::result_t             mem_reg [sled_pkg::FIFO_DEPTH];
    logic [sled_pkg::PTR_W-1:0]    wr_reg, rd_reg;
    logic [sled_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [sled_pkg::PTR_W-1:0]    wr_plus1;

    assign wr_plus1   = wr_reg + 1'b1;
    assign head       = mem_reg[rd_reg];
    assign head_valid = (fill_reg != '0);
    assign room       = (fill_reg <= sled_pkg::FILL_W'(sled_pkg::FIFO_DEPTH - 2));
    assign fill_next  = fill_reg + sled_pkg::FILL_W'(push.n) - sled_pkg::FILL_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wr_reg] <= push.first;
        if (push.n == 2'd2)
            mem_reg[wr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_reg + sled_pkg::PTR_W'(push.n);
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- hdl/string_literal_escape_decoder_top.sv -----
// String literal escape decoder, top level with APB register port.
//
// Takes one source character per word on in_word and decodes a delimited
// string literal (doubled delimiter, backslash escapes, octal and hex runs
// that wrap at 8 bits; code 0 ends the text). Each character gives zero, one
// or two result words on out_word: decoded bytes with a saturating per-literal
// count, end-of-string, missing-delimiter and unknown-escape words; last marks
// the final word of a character. The decoder takes a character every cycle:
// parsing is one combinational pass from the state registers into a four-word
// result queue, and in_word.ready is high whenever the queue has room for two
// words. Since out_word moves one word per cycle while its ready is high, the
// sustained rate is one character per cycle for characters that give at most
// one word; a character that gives two words lowers it. Each result word is
// registered in the queue. Registers (write only while idle):
// 0x0 delimiter [7:0], reset 0x22; 0x4 escapes enabled [0], reset 1.
module string_literal_escape_decoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    sled_in_if.sink                      in_word,
    sled_out_if.source                   out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sled_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0]        delimiter_reg;
    logic              esc_en_reg;
    logic              cfg_wr;
    logic              in_acc;
    logic              out_pop;
    logic              room;
    logic              head_valid;
    sled_pkg::push_t   push;
    sled_pkg::result_t head;

    // ---- configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= sled_pkg::DELIM_RESET;
            esc_en_reg    <= sled_pkg::ESC_EN_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == sled_pkg::REG_DELIMITER)
                delimiter_reg <= pwdata[7:0];
            else
                esc_en_reg <= pwdata[0];
        end
    end

    // register select by word address; upper data bits read as zero
    always_comb
    begin
        if (paddr[2] == sled_pkg::REG_ESC_EN)
            prdata = {31'd0, esc_en_reg};
        else
            prdata = {24'd0, delimiter_reg};
    end

    // ---- input side: accept while the queue can absorb a worst-case character
    assign in_word.ready = room;
    assign in_acc        = in_word.valid & room;

    sled_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_acc),
        .ch        (in_word.ch),
        .delimiter (delimiter_reg),
        .esc_en    (esc_en_reg),
        .push      (push)
    );

    // ---- result queue, head drives the output channel
    sled_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_pop),
        .head       (head),
        .head_valid (head_valid),
        .room       (room)
    );

    assign out_word.valid      = head_valid;
    assign out_word.code       = head.code;
    assign out_word.kind       = head.kind;
    assign out_word.byte_count = head.byte_count;
    assign out_word.last       = head.last;
    assign out_pop             = head_valid & out_word.ready;

    // ---- checks
    // no words appear without an accepted character
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |-> push.n == 2'd0)
        else $error("result words pushed without an accepted character");

    // at most two words per character
    a_push_max_two: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("more than two result words for one character");

    // with two words only the second is marked last
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> (!push.first.last && push.second.last))
        else $error("last flag misplaced in a word pair");

    // input stall only while output words are pending
    a_stall_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        !in_word.ready |-> out_word.valid)
        else $error("input stalled with empty result queue");

endmodule

// ----- tb/tb_string_literal_escape_decoder_top.sv -----
// Self-checking testbench for the string literal escape decoder top level.
module tb_string_literal_escape_decoder_top;

    // Quiet cycles (nothing accepted on either channel) before the run is
    // declared hung. The worst legal gap is a long sender idle run or receiver
    // stall at 86 percent, plus a register write and a drain tail.
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles allowed after the last expected word before touching registers
    localparam int DRAIN_TAIL     = 4;

    localparam logic [7:0] CH_7     = "7";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_F = "f";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_F  = "F";
    localparam logic [7:0] CH_Q     = "q";

    typedef enum logic [2:0] {
        P_OPEN,
        P_BODY,
        P_QUOTE,
        P_ESC,
        P_OCT,
        P_HEX
    } parse_phase_t;

    // ------------------------------------------------------------------
    // Clock, reset, block instance
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // TB-side drive variables start known at time zero; the interfaces are
    // driven from them continuously.
    logic       char_valid = 1'b0;
    logic [7:0] char_data  = sled_pkg::CH_NUL;
    logic       word_ready = 1'b0;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [sled_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    sled_in_if  in_ch();
    sled_out_if out_res();

    assign in_ch.valid   = char_valid;
    assign in_ch.ch      = char_data;
    assign out_res.ready = word_ready;

    string_literal_escape_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_ch),
        .out_word (out_res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Decoder prediction: own copy of registers and parse state
    // ------------------------------------------------------------------
    logic [7:0]                      cfg_delim = sled_pkg::DELIM_RESET;
    logic                            cfg_esc   = sled_pkg::ESC_EN_RESET;
    parse_phase_t                    dec_phase = P_OPEN;
    logic [7:0]                      dec_accum = '0;
    logic [sled_pkg::COUNT_BITS-1:0] dec_count = '0;

    sled_pkg::result_t expected_words[$];  // decoded words still owed by the block
    logic [7:0]        pending_chars[$];   // characters not yet offered
    int                fed_count      = 0;
    int                mismatches     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;

    task automatic push_word(input logic [7:0] c, input sled_pkg::kind_t k);
        sled_pkg::result_t w;
        w.code       = c;
        w.kind       = k;
        w.byte_count = sled_pkg::BCOUNT_W'(dec_count);
        w.last       = 1'b0;
        expected_words.push_back(w);
    endtask

    // count saturates at all-ones and is reported including this byte
    task automatic push_byte(input logic [7:0] b);
        if (dec_count != '1)
            dec_count = dec_count + 1'b1;
        push_word(b, sled_pkg::KIND_BYTE);
    endtask

    // ordinary body character; backslash is tested ahead of the delimiter
    task automatic body_char(input logic [7:0] c);
        if (c == sled_pkg::CH_NUL)
        begin
            push_word(sled_pkg::CH_NUL, sled_pkg::KIND_MISSING);
            dec_phase = P_OPEN;
        end
        else if (c == sled_pkg::CH_BACKSLASH)
        begin
            if (cfg_esc)
                dec_phase = P_ESC;
            else
            begin
                push_byte(c);
                dec_phase = P_BODY;
            end
        end
        else if (c == cfg_delim)
            dec_phase = P_QUOTE;
        else
        begin
            push_byte(c);
            dec_phase = P_BODY;
        end
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= sled_pkg::CH_ZERO && c <= CH_9)
            return int'(c - sled_pkg::CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_F)
            return int'(c - CH_LOW_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    // Works out every word one accepted character causes, in order, and
    // flags the final one with last.
    task automatic decode_char(input logic [7:0] c);
        int                n_before;
        int                nib;
        sled_pkg::result_t tail;
        n_before = expected_words.size();
        case (dec_phase)
            P_OPEN:
            begin
                if (c == sled_pkg::CH_NUL)
                    push_word(sled_pkg::CH_NUL, sled_pkg::KIND_MISSING);
                else
                begin
                    dec_count = '0;
                    dec_accum = '0;
                    if (c == cfg_delim)
                        dec_phase = P_BODY;
                    else
                    begin
                        // missing opener: flag it, then take c as body
                        push_word(sled_pkg::CH_NUL, sled_pkg::KIND_MISSING);
                        body_char(c);
                    end
                end
            end
            P_BODY:
                body_char(c);
            P_QUOTE:
            begin
                if (c != sled_pkg::CH_NUL && c == cfg_delim)
                begin
                    push_byte(c);
                    dec_phase = P_BODY;
                end
                else
                begin
                    // follower character is swallowed into the end word
                    push_word(c, sled_pkg::KIND_END);
                    dec_phase = P_OPEN;
                end
            end
            P_ESC:
            begin
                dec_phase = P_BODY;
                case (c)
                    sled_pkg::CH_NUL:
                    begin
                        push_word(sled_pkg::CH_NUL, sled_pkg::KIND_MISSING);
                        dec_phase = P_OPEN;
                    end
                    sled_pkg::LTR_B:        push_byte(sled_pkg::CH_BSPACE);
                    sled_pkg::LTR_F:        push_byte(sled_pkg::CH_FFEED);
                    sled_pkg::LTR_N:        push_byte(sled_pkg::CH_LFEED);
                    sled_pkg::LTR_R:        push_byte(sled_pkg::CH_CRET);
                    sled_pkg::LTR_T:        push_byte(sled_pkg::CH_TAB);
                    sled_pkg::LTR_E:        push_byte(sled_pkg::CH_ESCAPE);
                    sled_pkg::CH_BACKSLASH: push_byte(sled_pkg::CH_BACKSLASH);
                    sled_pkg::CH_DQUOTE:    push_byte(sled_pkg::CH_DQUOTE);
                    sled_pkg::CH_SQUOTE:    push_byte(sled_pkg::CH_SQUOTE);
                    sled_pkg::LTR_X, sled_pkg::LTR_UX:
                    begin
                        dec_accum = '0;
                        dec_phase = P_HEX;
                    end
                    default:
                    begin
                        if (c >= sled_pkg::CH_ZERO && c <= CH_7)
                        begin
                            dec_accum = c - sled_pkg::CH_ZERO;
                            dec_phase = P_OCT;
                        end
                        else
                        begin
                            // unknown escape: report, then reuse as body char
                            push_word(c, sled_pkg::KIND_UNKNOWN);
                            body_char(c);
                        end
                    end
                endcase
            end
            P_OCT:
            begin
                if (c >= sled_pkg::CH_ZERO && c <= CH_7)
                    dec_accum = {dec_accum[4:0], 3'(c - sled_pkg::CH_ZERO)};
                else
                begin
                    push_byte(dec_accum);
                    body_char(c);
                end
            end
            P_HEX:
            begin
                nib = hex_nibble(c);
                if (nib >= 0)
                    dec_accum = {dec_accum[3:0], 4'(nib)};
                else
                begin
                    push_byte(dec_accum);
                    body_char(c);
                end
            end
            default:
                dec_phase = P_OPEN;
        endcase
        if (expected_words.size() > n_before)
        begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Character driver: offers queued characters, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_data  <= sled_pkg::CH_NUL;
        end
        else
        begin
            if (char_valid && in_ch.ready)
                decode_char(char_data);
            // new word only once the current one is gone
            if (!char_valid || in_ch.ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    char_valid <= 1'b1;
                    char_data  <= pending_chars.pop_front();
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : word_monitor
        sled_pkg::result_t want;
        if (!rst_n)
            word_ready <= 1'b0;
        else
        begin
            if (out_res.valid && word_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word code %02h kind %0d",
                                              out_res.code, out_res.kind));
                else
                begin
                    want = expected_words.pop_front();
                    if (out_res.code !== want.code)
                        report_mismatch($sformatf("code %02h, want %02h",
                                                  out_res.code, want.code));
                    if (out_res.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  out_res.kind, want.kind));
                    if (out_res.byte_count !== want.byte_count)
                        report_mismatch($sformatf("byte_count %0d, want %0d",
                                                  out_res.byte_count, want.byte_count));
                    if (out_res.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  out_res.last, want.last));
                end
            end
            word_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: restarts on any accepted word on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin : hang_watch
        if (!rst_n || (char_valid && in_ch.ready) || (out_res.valid && word_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic feed(input logic [7:0] c);
        pending_chars.push_back(c);
        fed_count++;
    endtask

    // Nothing queued, nothing on the wire, nothing owed; then a short tail
    // so a character that gave no word has cleared the parser too.
    task automatic wait_drained();
        while (pending_chars.size() != 0 || char_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // APB write followed by a read-back; only called with the block idle.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [sled_pkg::ADDR_W-1:0] addr;
        logic [31:0]                 want;
        addr = {idx, 2'b00};
        want = (idx == sled_pkg::REG_DELIMITER) ? {24'd0, value[7:0]} : {31'd0, value[0]};
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // straight into the setup cycle of the read-back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %08h, want %08h",
                                      idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == sled_pkg::REG_DELIMITER)
            cfg_delim = value[7:0];
        else
            cfg_esc = value[0];
    endtask

    task automatic set_config(input logic [7:0] delim, input logic esc);
        write_reg(sled_pkg::REG_DELIMITER, {24'd0, delim});
        write_reg(sled_pkg::REG_ESC_EN, {31'd0, esc});
    endtask

    // non-zero, not a backslash, not the current delimiter
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == sled_pkg::CH_BACKSLASH || c == cfg_delim);
        return c;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 8))
            0:       return sled_pkg::LTR_B;
            1:       return sled_pkg::LTR_F;
            2:       return sled_pkg::LTR_N;
            3:       return sled_pkg::LTR_R;
            4:       return sled_pkg::LTR_T;
            5:       return sled_pkg::LTR_E;
            6:       return sled_pkg::CH_BACKSLASH;
            7:       return sled_pkg::CH_DQUOTE;
            default: return sled_pkg::CH_SQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return sled_pkg::CH_ZERO + 8'(r);
        if (r < 16)
            return CH_LOW_A + 8'(r - 10);
        return CH_UP_A + 8'(r - 16);
    endfunction

    // One literal, mostly well formed: opener, random mix of body pieces,
    // then a close with a random follower or a broken ending.
    task automatic queue_literal();
        int sel;
        int n_parts;
        int n_dig;
        sel = $urandom_range(99);
        if (sel < 90)
            feed(cfg_delim);
        else if (sel < 95)
            feed(plain_char());
        else
            feed(sled_pkg::CH_NUL);
        n_parts = $urandom_range(0, 10);
        for (int k = 0; k < n_parts; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                feed(plain_char());
            else if (sel < 52)
            begin
                feed(cfg_delim);
                feed(cfg_delim);
            end
            else if (sel < 70)
            begin
                feed(sled_pkg::CH_BACKSLASH);
                feed(escape_letter());
            end
            else if (sel < 80)
            begin
                // octal run of up to four digits, enough to wrap past 8 bits
                feed(sled_pkg::CH_BACKSLASH);
                n_dig = $urandom_range(1, 4);
                for (int d = 0; d < n_dig; d++)
                    feed(sled_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
            end
            else if (sel < 90)
            begin
                // hex run, possibly with no digits at all
                feed(sled_pkg::CH_BACKSLASH);
                feed($urandom_range(1) ? sled_pkg::LTR_X : sled_pkg::LTR_UX);
                n_dig = $urandom_range(0, 3);
                for (int d = 0; d < n_dig; d++)
                    feed(hex_char());
            end
            else if (sel < 96)
            begin
                feed(sled_pkg::CH_BACKSLASH);
                feed(8'($urandom_range(1, 255)));
            end
            else
                feed(8'($urandom_range(0, 255)));
        end
        sel = $urandom_range(99);
        if (sel < 85)
        begin
            feed(cfg_delim);
            feed(8'($urandom_range(0, 255)));
        end
        else if (sel < 92)
            feed(sled_pkg::CH_NUL);
        else
        begin
            feed(sled_pkg::CH_BACKSLASH);
            feed(sled_pkg::CH_NUL);
        end
    endtask

    // One idling profile; the source pauses for a full drain halfway through.
    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int   first;
        logic paused;
        first          = fed_count;
        paused         = 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (fed_count - first < n_items)
        begin
            if ($urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)));
            end
            else
                queue_literal();
            if (!paused && fed_count - first >= n_items / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            // keep the backlog short so each profile applies to its own items
            while (pending_chars.size() > 16)
                @(posedge clk);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_seq
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: top byte value, every escape letter but
        // the double quote, an unknown escape, empty hex run closed by the
        // delimiter, doubled delimiter, close with follower, end of text before
        // the opener, missing opener, end of text inside the body.
        feed(sled_pkg::CH_DQUOTE);
        feed(8'hFF);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_B);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_F);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_N);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_R);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_T);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::CH_BACKSLASH);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::CH_SQUOTE);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_E);
        feed(sled_pkg::CH_BACKSLASH); feed(CH_Q);
        feed(sled_pkg::CH_BACKSLASH); feed(sled_pkg::LTR_X);
        feed(sled_pkg::CH_DQUOTE);
        feed(sled_pkg::CH_DQUOTE);
        feed(sled_pkg::CH_DQUOTE);
        feed(8'h01);
        feed(sled_pkg::CH_NUL);
        feed(CH_UP_A);
        feed(sled_pkg::CH_NUL);
        wait_drained();

        // register writes of the reset values, then random phases
        set_config(sled_pkg::DELIM_RESET, sled_pkg::ESC_EN_RESET);
        run_phase(0, 0, 250);

        set_config(sled_pkg::CH_SQUOTE, 1'b0);
        run_phase(86, 0, 200);

        set_config(8'hFF, 1'b1);
        run_phase(0, 86, 250);

        // delimiter zero: the literal can never open or close
        set_config(sled_pkg::CH_NUL, 1'b1);
        run_phase(19, 19, 150);

        // delimiter equal to backslash, escapes on
        set_config(sled_pkg::CH_BACKSLASH, 1'b1);
        run_phase(86, 0, 150);

        set_config(8'($urandom_range(1, 255)), 1'b0);
        run_phase(0, 86, 150);

        set_config(sled_pkg::CH_DQUOTE, 1'b1);
        run_phase(19, 19, 250);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
